// ===== design/hctf_pkg.sv =====
`default_nettype none
package hctf_pkg;

  localparam int unsigned SMP_W   = 24;
  localparam int unsigned CFG_W   = 24;
  localparam int unsigned CADDR_W = 3;
  localparam int unsigned RUN_MAX = 4;

  // Register indexes on the configuration port.
  localparam logic [CADDR_W-1:0] REG_ADC_RES   = 3'd0;
  localparam logic [CADDR_W-1:0] REG_SMP_RATE  = 3'd1;
  localparam logic [CADDR_W-1:0] REG_VREF_HALF = 3'd2;
  localparam logic [CADDR_W-1:0] REG_HB_PERIOD = 3'd3;
  localparam logic [CADDR_W-1:0] REG_TIMEOUT   = 3'd4;

  localparam logic [4:0]  ADC_RES_RST   = 5'd20;
  localparam logic [15:0] SMP_RATE_RST  = 16'd1000;
  localparam logic [15:0] VREF_HALF_RST = 16'd2500;
  localparam logic [15:0] HB_PERIOD_RST = 16'd1000;
  localparam logic [23:0] TIMEOUT_RST   = 24'd240000;
  localparam logic [7:0]  DAC_RST       = 8'd148;
  localparam logic [3:0]  GAIN_MAX      = 4'd8;

  localparam logic [7:0] GUARD_BYTE = 8'hAB;
  localparam logic [7:0] CMD_STREAM = 8'hA1;
  localparam logic [7:0] CMD_REPORT = 8'hA5;
  localparam logic [7:0] CMD_GAIN   = 8'hA6;
  localparam logic [7:0] CMD_SOURCE = 8'hA8;
  localparam logic [7:0] CMD_OGAIN  = 8'hA9;
  localparam logic [7:0] CMD_DAC    = 8'hAA;

  typedef enum logic [1:0] {
    REQ_BYTE     = 2'd0,
    REQ_RAW      = 2'd1,
    REQ_FILTERED = 2'd2,
    REQ_TICK     = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    FT_DATA  = 3'd0,
    FT_HBEAT = 3'd1,
    FT_CFG2  = 3'd2,
    FT_CFG3  = 3'd3,
    FT_CFG4  = 3'd4,
    FT_ACK   = 3'd7
  } ftype_t;

  typedef enum logic [1:0] {
    PS_GUARD = 2'd0,
    PS_CMD   = 2'd1,
    PS_PARAM = 2'd2,
    PS_CHECK = 2'd3
  } pstate_t;

  typedef struct packed {
    logic [1:0]              req_type;
    logic [7:0]              rx_byte;
    logic signed [SMP_W-1:0] sample_value;
  } in_item_t;

  typedef struct packed {
    logic       led_on;
    logic [3:0] gain_code;
    logic [3:0] offset_gain_code;
    logic [7:0] dac_value;
    logic       stream_on;
    logic       filtered_mode;
  } status_t;

  typedef struct packed {
    logic [2:0] frame_type;
    logic [7:0] payload_a;
    logic [7:0] payload_b;
    logic [7:0] payload_c;
  } frame_t;

  typedef struct packed {
    logic [2:0]       count;
    frame_t [RUN_MAX-1:0] frames;
    status_t          status;
  } run_t;

  typedef struct packed {
    logic [2:0] frame_type;
    logic [7:0] payload_a;
    logic [7:0] payload_b;
    logic [7:0] payload_c;
    logic       last_of_run;
    logic       led_on;
    logic [3:0] gain_code;
    logic [3:0] offset_gain_code;
    logic [7:0] dac_value;
    logic       stream_on;
    logic       filtered_mode;
  } out_item_t;

endpackage
`default_nettype wire

// ===== design/host_command_and_telemetry_framer_top.sv =====
`default_nettype none
// Host command and telemetry framer. Each input transfer (host byte, raw or
// filtered sample, or timer tick) is decoded in the cycle it is taken and
// leaves zero to four frames in a run buffer, which drains one frame per
// cycle on the out channel while out_ready is high; last_of_run marks the
// final frame of each run. A new input is taken as soon as the buffer is
// empty or its last frame is being transferred, so no new input is taken
// while a run is pending. Ticks, bytes that complete no command and dropped
// samples leave no frames, streamed samples leave one or two, and a command
// up to four. The run buffer and out_ready back-pressure set the rate.
// Configuration writes take effect on the next input transfer.
module host_command_and_telemetry_framer_top #(
  parameter int unsigned SAMPLE_BITS = 24
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire hctf_pkg::in_item_t           in_data,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output hctf_pkg::out_item_t               out_data,
  input  wire logic                         cfg_we,
  input  wire logic [hctf_pkg::CADDR_W-1:0] cfg_addr,
  input  wire logic [hctf_pkg::CFG_W-1:0]   cfg_wdata
);

  hctf_pkg::run_t run;
  logic           take;
  logic           pop;

  logic [2:0]                              cnt_r, cnt_nxt;
  hctf_pkg::frame_t [hctf_pkg::RUN_MAX-1:0] frames_r, frames_nxt;
  hctf_pkg::status_t                       status_r, status_nxt;

  assign out_valid = (cnt_r != 3'd0);
  assign pop       = out_valid && out_ready;
  assign in_ready  = (cnt_r == 3'd0) || (pop && (cnt_r == 3'd1));
  assign take      = in_valid && in_ready;

  hctf_core #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .take     (take),
    .item     (in_data),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .run      (run)
  );

  always_comb begin
    cnt_nxt    = cnt_r;
    frames_nxt = frames_r;
    status_nxt = status_r;
    if (take) begin
      cnt_nxt    = run.count;
      frames_nxt = run.frames;
      status_nxt = run.status;
    end else if (pop) begin
      // Shift the run down so the head frame always sits in slot zero.
      cnt_nxt = cnt_r - 3'd1;
      for (int k = 0; k < hctf_pkg::RUN_MAX - 1; k++) begin
        frames_nxt[k] = frames_r[k+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    frames_r <= frames_nxt;
    status_r <= status_nxt;
  end

  assign out_data = '{
    frame_type:       frames_r[0].frame_type,
    payload_a:        frames_r[0].payload_a,
    payload_b:        frames_r[0].payload_b,
    payload_c:        frames_r[0].payload_c,
    last_of_run:      (cnt_r == 3'd1),
    led_on:           status_r.led_on,
    gain_code:        status_r.gain_code,
    offset_gain_code: status_r.offset_gain_code,
    dac_value:        status_r.dac_value,
    stream_on:        status_r.stream_on,
    filtered_mode:    status_r.filtered_mode
  };

endmodule
`default_nettype wire

// ===== design/hctf_core.sv =====
`default_nettype none
module hctf_core #(
  parameter int unsigned SAMPLE_BITS = 24
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              take,
  input  wire hctf_pkg::in_item_t                item,
  input  wire logic                              cfg_we,
  input  wire logic [hctf_pkg::CADDR_W-1:0]      cfg_addr,
  input  wire logic [hctf_pkg::CFG_W-1:0]        cfg_wdata,
  output hctf_pkg::run_t                         run
);

  logic [4:0]  adc_res_r;
  logic [15:0] smp_rate_r;
  logic [15:0] vref_half_r;
  logic [15:0] hb_period_r;
  logic [23:0] timeout_r;

  hctf_pkg::pstate_t pstate_r, pstate_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [7:0]  param_r, param_nxt;
  logic        armed_r, armed_nxt;
  logic [23:0] tcount_r, tcount_nxt;
  logic        stream_r, stream_nxt;
  logic        filt_r, filt_nxt;
  logic [3:0]  gain_r, gain_nxt;
  logic [3:0]  ogain_r, ogain_nxt;
  logic [7:0]  dac_r, dac_nxt;
  logic [15:0] hb_r, hb_nxt;
  logic        led_r, led_nxt;

  logic signed [SAMPLE_BITS-1:0] smp_narrow;
  logic [hctf_pkg::SMP_W-1:0]    smp_ext;

  assign smp_narrow = item.sample_value[SAMPLE_BITS-1:0];
  assign smp_ext    = hctf_pkg::SMP_W'(smp_narrow);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      adc_res_r   <= hctf_pkg::ADC_RES_RST;
      smp_rate_r  <= hctf_pkg::SMP_RATE_RST;
      vref_half_r <= hctf_pkg::VREF_HALF_RST;
      hb_period_r <= hctf_pkg::HB_PERIOD_RST;
      timeout_r   <= hctf_pkg::TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        hctf_pkg::REG_ADC_RES:   adc_res_r   <= cfg_wdata[4:0];
        hctf_pkg::REG_SMP_RATE:  smp_rate_r  <= cfg_wdata[15:0];
        hctf_pkg::REG_VREF_HALF: vref_half_r <= cfg_wdata[15:0];
        hctf_pkg::REG_HB_PERIOD: hb_period_r <= cfg_wdata[15:0];
        hctf_pkg::REG_TIMEOUT:   timeout_r   <= cfg_wdata[23:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pstate_r <= hctf_pkg::PS_GUARD;
      cmd_r    <= '0;
      param_r  <= '0;
      armed_r  <= 1'b0;
      tcount_r <= '0;
      stream_r <= 1'b0;
      filt_r   <= 1'b0;
      gain_r   <= '0;
      ogain_r  <= '0;
      dac_r    <= hctf_pkg::DAC_RST;
      hb_r     <= '0;
      led_r    <= 1'b0;
    end else if (take) begin
      pstate_r <= pstate_nxt;
      cmd_r    <= cmd_nxt;
      param_r  <= param_nxt;
      armed_r  <= armed_nxt;
      tcount_r <= tcount_nxt;
      stream_r <= stream_nxt;
      filt_r   <= filt_nxt;
      gain_r   <= gain_nxt;
      ogain_r  <= ogain_nxt;
      dac_r    <= dac_nxt;
      hb_r     <= hb_nxt;
      led_r    <= led_nxt;
    end
  end

  always_comb begin
    logic        exec;
    logic        push_ack;
    logic        push_cfg;
    logic        push_data;
    logic        push_hb;
    logic [7:0]  ack_a;
    logic [7:0]  ack_b;
    logic [24:0] tnext;
    logic [16:0] hnext;
    logic        want_filt;
    logic [2:0]  n;
    hctf_pkg::frame_t [2:0] cfgf;

    pstate_nxt = pstate_r;
    cmd_nxt    = cmd_r;
    param_nxt  = param_r;
    armed_nxt  = armed_r;
    tcount_nxt = tcount_r;
    stream_nxt = stream_r;
    filt_nxt   = filt_r;
    gain_nxt   = gain_r;
    ogain_nxt  = ogain_r;
    dac_nxt    = dac_r;
    hb_nxt     = hb_r;
    led_nxt    = led_r;
    exec       = 1'b0;
    push_ack   = 1'b0;
    push_cfg   = 1'b0;
    push_data  = 1'b0;
    push_hb    = 1'b0;
    ack_a      = cmd_r;
    ack_b      = '0;
    tnext      = {1'b0, tcount_r} + 25'd1;
    hnext      = {1'b0, hb_r} + 17'd1;
    want_filt  = (item.req_type == hctf_pkg::REQ_FILTERED);

    case (item.req_type)
      hctf_pkg::REQ_BYTE: begin
        case (pstate_r)
          hctf_pkg::PS_GUARD: begin
            if (item.rx_byte == hctf_pkg::GUARD_BYTE) begin
              pstate_nxt = hctf_pkg::PS_CMD;
              armed_nxt  = 1'b1;
              tcount_nxt = '0;
            end
          end
          hctf_pkg::PS_CMD: begin
            armed_nxt  = 1'b1;
            tcount_nxt = '0;
            if (item.rx_byte inside {hctf_pkg::CMD_STREAM, hctf_pkg::CMD_REPORT,
                                     hctf_pkg::CMD_GAIN, hctf_pkg::CMD_SOURCE,
                                     hctf_pkg::CMD_OGAIN, hctf_pkg::CMD_DAC}) begin
              cmd_nxt    = item.rx_byte;
              pstate_nxt = hctf_pkg::PS_PARAM;
            end else begin
              pstate_nxt = hctf_pkg::PS_GUARD;
              armed_nxt  = 1'b0;
            end
          end
          hctf_pkg::PS_PARAM: begin
            param_nxt  = item.rx_byte;
            pstate_nxt = hctf_pkg::PS_CHECK;
            armed_nxt  = 1'b1;
            tcount_nxt = '0;
          end
          default: begin
            pstate_nxt = hctf_pkg::PS_GUARD;
            armed_nxt  = 1'b0;
            tcount_nxt = '0;
            exec       = (item.rx_byte == (cmd_r ^ param_r));
          end
        endcase
      end
      hctf_pkg::REQ_TICK: begin
        if (armed_r) begin
          if (tnext >= {1'b0, timeout_r}) begin
            pstate_nxt = hctf_pkg::PS_GUARD;
            cmd_nxt    = '0;
            param_nxt  = '0;
            armed_nxt  = 1'b0;
            tcount_nxt = '0;
          end else begin
            tcount_nxt = tnext[23:0];
          end
        end
      end
      default: begin
        if (stream_r && (filt_r == want_filt)) begin
          push_data = 1'b1;
          if (hnext >= {1'b0, hb_period_r}) begin
            hb_nxt  = '0;
            push_hb = 1'b1;
          end else begin
            hb_nxt = hnext[15:0];
          end
        end
      end
    endcase

    if (exec) begin
      case (cmd_r)
        hctf_pkg::CMD_REPORT: push_cfg = 1'b1;
        hctf_pkg::CMD_STREAM: begin
          stream_nxt = (param_r != 8'd0);
          push_ack   = 1'b1;
          ack_b      = {7'd0, stream_nxt};
          push_cfg   = stream_nxt;
          led_nxt    = ~led_r;
        end
        hctf_pkg::CMD_GAIN: begin
          if (param_r <= {4'd0, hctf_pkg::GAIN_MAX}) gain_nxt = param_r[3:0];
          push_cfg = 1'b1;
          led_nxt  = ~led_r;
        end
        hctf_pkg::CMD_SOURCE: begin
          filt_nxt = (param_r != 8'd0);
          push_ack = 1'b1;
          ack_b    = {7'd0, filt_nxt};
        end
        hctf_pkg::CMD_OGAIN: begin
          if (param_r <= {4'd0, hctf_pkg::GAIN_MAX}) ogain_nxt = param_r[3:0];
          push_ack = 1'b1;
          ack_b    = {4'd0, ogain_nxt};
          push_cfg = 1'b1;
          led_nxt  = ~led_r;
        end
        hctf_pkg::CMD_DAC: begin
          dac_nxt  = param_r;
          push_ack = 1'b1;
          ack_b    = param_r;
          push_cfg = 1'b1;
          led_nxt  = ~led_r;
        end
        default: ;
      endcase
    end

    // Config frames report the settings as this command leaves them.
    cfgf[0] = '{hctf_pkg::FT_CFG2, {3'd0, adc_res_r}, smp_rate_r[15:8], smp_rate_r[7:0]};
    cfgf[1] = '{hctf_pkg::FT_CFG3, {4'd0, gain_nxt}, vref_half_r[15:8], vref_half_r[7:0]};
    cfgf[2] = '{hctf_pkg::FT_CFG4, {4'd0, ogain_nxt}, dac_nxt, 8'd0};

    run.frames = '0;
    n = '0;
    if (push_ack) begin
      run.frames[n[1:0]] = '{hctf_pkg::FT_ACK, ack_a, ack_b, 8'd0};
      n = n + 3'd1;
    end
    if (push_cfg) begin
      for (int k = 0; k < 3; k++) begin
        run.frames[n[1:0]] = cfgf[k];
        n = n + 3'd1;
      end
    end
    if (push_data) begin
      run.frames[n[1:0]] = '{hctf_pkg::FT_DATA, smp_ext[23:16], smp_ext[15:8], smp_ext[7:0]};
      n = n + 3'd1;
    end
    if (push_hb) begin
      run.frames[n[1:0]] = '{hctf_pkg::FT_HBEAT, {4'd0, gain_r}, dac_r, {7'd0, filt_r}};
      n = n + 3'd1;
    end
    run.count  = n;
    run.status = '{led_nxt, gain_nxt, ogain_nxt, dac_nxt, stream_nxt, filt_nxt};
  end

endmodule
`default_nettype wire

// ===== design/hctf_checker.sv =====
`default_nettype none
module hctf_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire hctf_pkg::out_item_t out_data
);

  // A stalled frame must hold.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("out frame changed while stalled");

  // Inputs are only taken once the pending run has been fully delivered.
  a_ready_gap: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid || (out_ready && out_data.last_of_run))
    else $error("input taken while frames of a run were pending");

  // A run keeps going until its last frame has been transferred.
  a_run_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.last_of_run |=> out_valid)
    else $error("run ended without a last frame");

  // Every frame of one run reports the same LED, DAC, gain and stream settings.
  a_run_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.last_of_run |=>
      $stable(out_data.led_on) && $stable(out_data.dac_value) &&
      $stable(out_data.gain_code) && $stable(out_data.stream_on))
    else $error("settings changed inside a run");

  a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.gain_code <= 4'd8 && out_data.offset_gain_code <= 4'd8)
    else $error("gain code out of range");

endmodule

bind host_command_and_telemetry_framer_top hctf_checker u_hctf_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);
`default_nettype wire
